[hw/rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Types, constants and tables shared by the theta series evaluator.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int CoefWidth    = 32;
  localparam int AccWidth     = 48;
  localparam int CordicStages = 24;
  localparam int CordicWidth  = 34;
  localparam int IterWidth    = $clog2(CordicStages);
  localparam int NumKinds     = 12;

  localparam logic [1:0] CFG_BASIS_KIND  = 2'd0;
  localparam logic [1:0] CFG_ANGLE_PHASE = 2'd1;
  localparam logic [1:0] CFG_THETA_COUNT = 2'd2;

  localparam logic [1:0] MUL_J    = 2'd0;
  localparam logic [1:0] MUL_2J   = 2'd1;
  localparam logic [1:0] MUL_2J_1 = 2'd2;

  localparam logic FN_COS = 1'b0;
  localparam logic FN_SIN = 1'b1;

  typedef struct packed {
    logic signed [CoefWidth-1:0] coefficient;
    logic [5:0]                  theta_index;
    logic [6:0]                  phi_index;
    logic                        last_in_row;
  } in_item_t;

  typedef struct packed {
    logic signed [AccWidth-1:0] row_sum;
    logic [6:0]                 row_index;
    logic                       bad_basis;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  basis_kind;
    logic [31:0] angle_phase;
    logic [6:0]  theta_count;
  } cfg_t;

  typedef struct packed {
    logic [31:0]                 phase;
    logic                        want_sin;
    logic                        zero_term;
    logic                        bad;
    logic signed [CoefWidth-1:0] coef;
    logic [6:0]                  row;
    logic                        last;
  } entry_t;

  typedef struct packed {
    logic       fn0;
    logic       fn1;
    logic [1:0] mul0;
    logic [1:0] mul1;
    logic       zero_last;
  } kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROT,
    B_MAP,
    B_MUL,
    B_ACC
  } back_state_t;

  function automatic kind_t kind_lookup(input logic [3:0] kind);
    kind_t d;
    unique case (kind)
      4'd0:    d = '{FN_COS, FN_COS, MUL_J,    MUL_J,    1'b0};
      4'd1:    d = '{FN_COS, FN_COS, MUL_2J,   MUL_2J,   1'b0};
      4'd2:    d = '{FN_COS, FN_COS, MUL_2J_1, MUL_2J_1, 1'b1};
      4'd3:    d = '{FN_SIN, FN_SIN, MUL_J,    MUL_J,    1'b0};
      4'd4:    d = '{FN_SIN, FN_SIN, MUL_2J,   MUL_2J,   1'b1};
      4'd5:    d = '{FN_SIN, FN_SIN, MUL_2J_1, MUL_2J_1, 1'b1};
      4'd6:    d = '{FN_COS, FN_SIN, MUL_2J,   MUL_2J_1, 1'b0};
      4'd7:    d = '{FN_COS, FN_SIN, MUL_2J_1, MUL_2J,   1'b0};
      4'd8:    d = '{FN_SIN, FN_COS, MUL_2J,   MUL_2J_1, 1'b0};
      4'd9:    d = '{FN_SIN, FN_COS, MUL_2J_1, MUL_2J,   1'b0};
      4'd10:   d = '{FN_COS, FN_SIN, MUL_J,    MUL_J,    1'b0};
      4'd11:   d = '{FN_SIN, FN_COS, MUL_J,    MUL_J,    1'b0};
      default: d = '{FN_COS, FN_COS, MUL_J,    MUL_J,    1'b0};
    endcase
    return d;
  endfunction

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [CordicWidth-1:0] atan_turn(input logic [IterWidth-1:0] i);
    logic [CordicWidth-1:0] a;
    unique case (i)
      5'd0:    a = 34'd536870912;
      5'd1:    a = 34'd316933406;
      5'd2:    a = 34'd167458907;
      5'd3:    a = 34'd85004756;
      5'd4:    a = 34'd42667331;
      5'd5:    a = 34'd21354465;
      5'd6:    a = 34'd10679838;
      5'd7:    a = 34'd5340245;
      5'd8:    a = 34'd2670163;
      5'd9:    a = 34'd1335087;
      5'd10:   a = 34'd667544;
      5'd11:   a = 34'd333772;
      5'd12:   a = 34'd166886;
      5'd13:   a = 34'd83443;
      5'd14:   a = 34'd41722;
      5'd15:   a = 34'd20861;
      5'd16:   a = 34'd10430;
      5'd17:   a = 34'd5215;
      5'd18:   a = 34'd2608;
      5'd19:   a = 34'd1304;
      5'd20:   a = 34'd652;
      5'd21:   a = 34'd326;
      5'd22:   a = 34'd163;
      5'd23:   a = 34'd81;
      5'd24:   a = 34'd41;
      5'd25:   a = 34'd20;
      5'd26:   a = 34'd10;
      5'd27:   a = 34'd5;
      5'd28:   a = 34'd3;
      5'd29:   a = 34'd1;
      5'd30:   a = 34'd1;
      default: a = 34'd0;
    endcase
    return a;
  endfunction

endpackage

[hw/rtl/tts_front.sv]
// ----------------------------------------------------------------------------
// tts_front
// Classifies one coefficient: drops row one, picks function and harmonic,
// forms the phase and flags terms that contribute nothing.
// ----------------------------------------------------------------------------
module tts_front (
  input  tts_pkg::cfg_t     cfg,
  input  tts_pkg::in_item_t item,
  output logic              keep,
  output tts_pkg::entry_t   entry
);
  import tts_pkg::*;

  kind_t       d;
  logic        m;
  logic [1:0]  mul_sel;
  logic [6:0]  mul;
  logic [38:0] phase_full;
  logic        bad;
  logic        zeroed;

  always_comb begin
    d       = kind_lookup(cfg.basis_kind);
    m       = item.phi_index[1];
    mul_sel = m ? d.mul1 : d.mul0;
    unique case (mul_sel)
      MUL_2J:   mul = {item.theta_index, 1'b0};
      MUL_2J_1: mul = {item.theta_index, 1'b1};
      default:  mul = {1'b0, item.theta_index};
    endcase
    phase_full = 39'(mul) * 39'(cfg.angle_phase);
    bad    = (cfg.basis_kind >= 4'(NumKinds));
    zeroed = d.zero_last && (cfg.theta_count != 7'd0)
             && ({1'b0, item.theta_index} == cfg.theta_count - 7'd1);
    keep   = (item.phi_index != 7'd1);

    entry.phase     = phase_full[31:0];
    entry.want_sin  = m ? d.fn1 : d.fn0;
    entry.zero_term = bad || zeroed;
    entry.bad       = bad;
    entry.coef      = item.coefficient;
    entry.row       = item.phi_index;
    entry.last      = item.last_in_row;
  end

endmodule

[hw/rtl/tts_queue.sv]
// ----------------------------------------------------------------------------
// tts_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module tts_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tts_pkg::entry_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output tts_pkg::entry_t pop_data
);
  import tts_pkg::*;

  entry_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/tts_back.sv]
// ----------------------------------------------------------------------------
// tts_back
// Iterative CORDIC, scaled product and saturating row accumulator with an
// output register.
// ----------------------------------------------------------------------------
module tts_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  tts_pkg::entry_t    q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output tts_pkg::out_item_t out_data
);
  import tts_pkg::*;

  localparam logic signed [CordicWidth-1:0] Gain = 34'sd652032874;
  localparam logic signed [CordicWidth-1:0] One  = 34'sd1073741824;
  localparam logic signed [AccWidth:0]      AccMax = (49'sd1 <<< (AccWidth-1)) - 49'sd1;
  localparam logic signed [AccWidth:0]      AccMin = -(49'sd1 <<< (AccWidth-1));

  back_state_t state_r, state_nxt;
  entry_t      ent_r;
  logic [1:0]  quad_r;
  logic [IterWidth-1:0] iter_r;
  logic signed [CordicWidth-1:0] x_r, y_r, z_r;
  logic [30:0] b_abs_r;
  logic [31:0] a_abs_r;
  logic        neg_r;
  logic [62:0] prod_r;
  logic signed [AccWidth-1:0] acc_r;
  logic        out_valid_r;
  out_item_t   out_r;

  logic [1:0]  q0;
  logic [31:0] rr;
  logic signed [CordicWidth-1:0] dx, dy, c, s, v, vc;
  logic [32:0] mag;
  logic signed [AccWidth:0] term, sum;
  logic        out_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    q0 = 2'((q_data.phase + 32'h2000_0000) >> 30);
    rr = q_data.phase - {q0, 30'd0};
    dx = y_r >>> iter_r;
    dy = x_r >>> iter_r;
    unique case (quad_r)
      2'd0: begin c = x_r;  s = y_r;  end
      2'd1: begin c = -y_r; s = x_r;  end
      2'd2: begin c = -x_r; s = -y_r; end
      default: begin c = y_r; s = -x_r; end
    endcase
    v = ent_r.want_sin ? s : c;
    priority if (v > One) vc = One;
    else if (v < -One) vc = -One;
    else vc = v;
    mag  = 33'((64'(prod_r) + 64'h2000_0000) >> 30);
    term = neg_r ? -49'(mag) : 49'(mag);
    sum  = 49'(acc_r) + term;
    if (sum > AccMax) sum = AccMax;
    if (sum < AccMin) sum = AccMin;

    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = q_data.zero_term ? B_ACC : B_ROT;
        end
      end
      B_ROT:  if (iter_r == IterWidth'(CordicStages - 1)) state_nxt = B_MAP;
      B_MAP:  state_nxt = B_MUL;
      B_MUL:  state_nxt = B_ACC;
      B_ACC:  if (!ent_r.last || out_free) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_ACC && ent_r.last && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == B_ACC && (!ent_r.last || out_free)) begin
        if (ent_r.last) begin
          acc_r <= '0;
        end else begin
          acc_r <= sum[AccWidth-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        ent_r  <= q_data;
        quad_r <= q0;
        iter_r <= '0;
        x_r    <= Gain;
        y_r    <= '0;
        z_r    <= CordicWidth'($signed(rr));
        prod_r <= '0;
        neg_r  <= 1'b0;
      end
      B_ROT: begin
        iter_r <= iter_r + IterWidth'(1);
        if (!z_r[CordicWidth-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - $signed(atan_turn(iter_r));
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + $signed(atan_turn(iter_r));
        end
      end
      B_MAP: begin
        b_abs_r <= vc[CordicWidth-1] ? 31'(-vc) : 31'(vc);
        a_abs_r <= ent_r.coef[CoefWidth-1] ? 32'(-ent_r.coef) : 32'(ent_r.coef);
        neg_r   <= ent_r.coef[CoefWidth-1] != vc[CordicWidth-1];
      end
      B_MUL: prod_r <= 63'(a_abs_r) * 63'(b_abs_r);
      B_ACC: begin
        if (ent_r.last && out_free) begin
          out_r.row_sum   <= ent_r.bad ? '0 : sum[AccWidth-1:0];
          out_r.row_index <= ent_r.row;
          out_r.bad_basis <= ent_r.bad;
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/theta_trig_series_eval_core.sv]
// ----------------------------------------------------------------------------
// theta_trig_series_eval_core
// Theta series evaluation at one configured angle, one sum per phi row.
//
//  channel | ports                         | transfer
//  input   | in_valid in_ready in_data     | valid & ready
//  result  | out_valid out_ready out_data  | valid & ready
//  config  | cfg_we cfg_index cfg_wdata    | cfg_we
//
// In the back end a term passes through 24 CORDIC iterations on one shared
// rotator, then map, multiply and accumulate; a zeroed or invalid-basis term goes
// directly to accumulate. A two-entry queue lets the front keep accepting while
// the back works. Row one items are taken and dropped. Synchronous reset clears
// control state and the accumulator. A held result stalls only a row's last term.
// ----------------------------------------------------------------------------
module theta_trig_series_eval_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tts_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);
  import tts_pkg::*;

  cfg_t   cfg_r;
  entry_t f_entry, q_head;
  logic   f_keep, q_full, q_ne, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.basis_kind  <= 4'd0;
      cfg_r.angle_phase <= 32'd0;
      cfg_r.theta_count <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASIS_KIND:  cfg_r.basis_kind  <= cfg_wdata[3:0];
        CFG_ANGLE_PHASE: cfg_r.angle_phase <= cfg_wdata;
        CFG_THETA_COUNT: cfg_r.theta_count <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;

  tts_front u_front (
    .cfg   (cfg_r),
    .item  (in_data),
    .keep  (f_keep),
    .entry (f_entry)
  );

  tts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready && f_keep),
    .push_data (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_ne),
    .pop_data  (q_head)
  );

  tts_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_ne),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[test/tts_row_checker.sv]
// ----------------------------------------------------------------------------
// tts_row_checker
// Watches the input and result channels of the theta series evaluator,
// computes each row sum independently and compares every result field.
// ----------------------------------------------------------------------------
module tts_row_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  tts_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  tts_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output int                 fail_count,
  output int                 sums_pending,
  output int                 sums_seen,
  output int                 items_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import tts_pkg::*;

  localparam longint Q30 = 64'sd1 << 30;
  localparam longint SUM_MAX = (64'sd1 << 47) - 1;
  localparam longint SUM_MIN = -(64'sd1 << 47);

  logic [3:0]  kind_q;
  logic [31:0] angle_q;
  logic [6:0]  count_q;
  longint      row_acc;
  out_item_t   sum_queue[$];

  longint arctan_turn[24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  // cos or sin of a turn fraction in Q1.30, by shift-and-add rotation
  function automatic longint trig_value(logic [31:0] ph, bit sine);
    logic [1:0]  quad;
    logic [31:0] resid;
    longint      z, x, y, dx, dy, c, s, v;
    quad  = 2'((ph + 32'h2000_0000) >> 30);
    resid = ph - {quad, 30'd0};
    z = longint'($signed(resid));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= arctan_turn[i];
      end else begin
        x += dx; y -= dy; z += arctan_turn[i];
      end
    end
    case (quad)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    v = sine ? s : c;
    if (v > Q30) v = Q30;
    if (v < -Q30) v = -Q30;
    return v;
  endfunction

  function automatic longint scaled_term(longint coef, longint basis);
    bit     neg;
    longint a, b, mag;
    neg = (coef < 0) != (basis < 0);
    a = coef < 0 ? -coef : coef;
    b = basis < 0 ? -basis : basis;
    mag = (a >>> 30) * b + (((a & 64'h3FFF_FFFF) * b + 64'h2000_0000) >>> 30);
    return neg ? -mag : mag;
  endfunction

  task automatic absorb_coefficient(in_item_t it);
    bit        bad, sine, zeroed, odd_row;
    logic [1:0] mul_sel;
    logic [31:0] mul, ph;
    longint    term, sum;
    out_item_t res;
    term = 0;
    if (it.phi_index == 7'd1) return;
    bad = kind_q >= 4'd12;
    odd_row = it.phi_index[1];
    if (!bad) begin
      sine    = 0;
      mul_sel = MUL_J;
      zeroed  = 0;
      case (kind_q)
        4'd0:  begin sine = 0; mul_sel = MUL_J; end
        4'd1:  begin sine = 0; mul_sel = MUL_2J; end
        4'd2:  begin sine = 0; mul_sel = MUL_2J_1; zeroed = 1; end
        4'd3:  begin sine = 1; mul_sel = MUL_J; end
        4'd4:  begin sine = 1; mul_sel = MUL_2J; zeroed = 1; end
        4'd5:  begin sine = 1; mul_sel = MUL_2J_1; zeroed = 1; end
        4'd6:  begin sine = odd_row; mul_sel = odd_row ? MUL_2J_1 : MUL_2J; end
        4'd7:  begin sine = odd_row; mul_sel = odd_row ? MUL_2J : MUL_2J_1; end
        4'd8:  begin sine = !odd_row; mul_sel = odd_row ? MUL_2J_1 : MUL_2J; end
        4'd9:  begin sine = !odd_row; mul_sel = odd_row ? MUL_2J : MUL_2J_1; end
        4'd10: begin sine = odd_row; mul_sel = MUL_J; end
        default: begin sine = !odd_row; mul_sel = MUL_J; end
      endcase
      zeroed = zeroed && count_q >= 7'd1 && {1'b0, it.theta_index} == count_q - 7'd1;
      mul = mul_sel == MUL_J ? 32'(it.theta_index) :
            mul_sel == MUL_2J ? 32'(it.theta_index) << 1 :
            (32'(it.theta_index) << 1) + 32'd1;
      if (!zeroed) begin
        ph = mul * angle_q;
        term = scaled_term(longint'(it.coefficient), trig_value(ph, sine));
      end
    end
    sum = row_acc + term;
    if (sum > SUM_MAX) sum = SUM_MAX;
    if (sum < SUM_MIN) sum = SUM_MIN;
    row_acc = sum;
    if (it.last_in_row) begin
      res.row_sum   = bad ? '0 : 48'(sum);
      res.row_index = it.phi_index;
      res.bad_basis = bad;
      sum_queue.push_back(res);
      row_acc = 0;
    end
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] row sum mismatch in %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      kind_q  <= 4'd0;
      angle_q <= 32'd0;
      count_q <= 7'd64;
      row_acc = 0;
      sum_queue.delete();
      fail_count = 0;
      sums_seen <= 0;
      items_seen <= 0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_coefficient(in_data);
        items_seen <= items_seen + 1;
      end
      if (out_valid && out_ready) begin
        sums_seen <= sums_seen + 1;
        if (sum_queue.size() == 0) begin
          $display("[%0t] unexpected row sum transfer for row %0d",
                   $realtime, out_data.row_index);
          fail_count++;
        end else begin
          want = sum_queue.pop_front();
          if (out_data.row_sum !== want.row_sum)
            report_mismatch("row_sum", longint'(out_data.row_sum), longint'(want.row_sum));
          if (out_data.row_index !== want.row_index)
            report_mismatch("row_index", out_data.row_index, want.row_index);
          if (out_data.bad_basis !== want.bad_basis)
            report_mismatch("bad_basis", out_data.bad_basis, want.bad_basis);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASIS_KIND:  kind_q  <= cfg_wdata[3:0];
          CFG_ANGLE_PHASE: angle_q <= cfg_wdata;
          CFG_THETA_COUNT: count_q <= cfg_wdata[6:0];
          default: ;
        endcase
      end
    end
  end

  assign sums_pending = sum_queue.size();
endmodule

[test/tb_theta_trig_series_eval_core.sv]
// ----------------------------------------------------------------------------
// tb_theta_trig_series_eval_core
// Drives coefficient rows through the theta series evaluator under a range
// of basis kinds, angles and term counts, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_theta_trig_series_eval_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tts_pkg::*;

  localparam int StallLimit = 20000;
  localparam int DrainCycles = 80;

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready;
  in_item_t   in_data;
  out_item_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_wdata;
  int fail_count, sums_pending, sums_seen, items_seen;
  int quiet_cycles;
  bit calm;
  int settings_used;

  theta_trig_series_eval_core dut (.*);

  tts_row_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure in bursts
  initial begin
    int burst;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 6);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("Test completed with failures");
      $finish;
    end
  end

  // valid stays high between items unless an idle burst drops it
  task automatic send_coefficient(logic signed [31:0] c, logic [5:0] j,
                                  logic [6:0] k, bit last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_data  <= '{coefficient: c, theta_index: j, phi_index: k, last_in_row: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    while (sums_pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic signed [31:0] pick_coefficient();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  // one row of the given length, with random indices or a natural j sequence
  task automatic send_row(int len);
    logic [6:0] k;
    int start;
    k = ($urandom_range(0, 9) == 0) ? 7'd1 : 7'($urandom_range(0, 127));
    start = $urandom_range(0, 63);
    for (int n = 0; n < len; n++)
      send_coefficient(pick_coefficient(),
                       ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'(start + n),
                       k, n == len - 1);
  endtask

  initial begin
    logic [31:0] angles[6] = '{32'd0, 32'hFFFF_FFFF, 32'h4000_0000, 32'h2000_0000,
                               32'h8000_0000, 32'h0123_4567};
    int sent;
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_BASIS_KIND;
    cfg_wdata = '0;
    settings_used = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, extremes and special rows
    send_coefficient(32'sh7FFF_FFFF, 6'd0, 7'd0, 1'b0);
    send_coefficient(32'sh7FFF_FFFF, 6'd63, 7'd0, 1'b1);
    send_coefficient(32'sh8000_0000, 6'd0, 7'd1, 1'b1);
    settle();
    write_register(CFG_ANGLE_PHASE, 32'h1000_0000);
    for (int kd = 0; kd < 16; kd++) begin
      write_register(CFG_BASIS_KIND, 32'(kd));
      write_register(CFG_THETA_COUNT, 32'(kd % 3 == 0 ? 64 : 5));
      send_coefficient(32'sh4000_0000, 6'd4, 7'd2, 1'b0);
      send_coefficient(32'sh8000_0000, 6'd63, 7'd127, 1'b1);
      settle();
    end
    // sum a row of full-scale terms at zero angle
    write_register(CFG_BASIS_KIND, 32'd0);
    write_register(CFG_ANGLE_PHASE, 32'd0);
    write_register(3, 32'hFFFF_FFFF);
    for (int n = 0; n < 8; n++)
      send_coefficient(32'sh7FFF_FFFF, 6'(n), 7'd64, 1'b0);
    send_coefficient(32'sh7FFF_FFFF, 6'd8, 7'd64, 1'b1);
    settle();

    sent = 0;
    while (sent < 1250) begin
      write_register(CFG_BASIS_KIND,
                     32'($urandom_range(0, 7) == 0 ? $urandom_range(12, 15)
                                                   : $urandom_range(0, 11)));
      write_register(CFG_ANGLE_PHASE,
                     $urandom_range(0, 2) == 0 ? angles[$urandom_range(0, 5)] : $urandom());
      write_register(CFG_THETA_COUNT,
                     32'($urandom_range(0, 5) == 0 ? $urandom_range(0, 127)
                                                   : $urandom_range(1, 64)));
      if (sent > 1100) calm = 1'b1;
      for (int r = 0; r < 6; r++) begin
        int len;
        len = $urandom_range(1, 8);
        send_row(len);
        sent += len;
      end
      settle();
    end

    calm = 1'b1;
    settle();
    $display("covered %0d coefficients, %0d row sums, %0d register writes",
             items_seen, sums_seen, settings_used);
    $display("basis kinds 0..15, angle extremes, term counts 0..127, rows 0..127");
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

[files.f]
hw/rtl/tts_pkg.sv
hw/rtl/tts_front.sv
hw/rtl/tts_queue.sv
hw/rtl/tts_back.sv
hw/rtl/theta_trig_series_eval_core.sv
test/tts_row_checker.sv
test/tb_theta_trig_series_eval_core.sv
